// ===== hw/rtl/qts_pkg.sv =====
// Package for the quoted token splitter: result descriptor type, push bundle
// between the scanner and the result queue, and character constants.
// Used by qts_scan, qts_rbuf and quoted_token_splitter.
package qts_pkg;

  // Longest string handled; characters beyond it are dropped.
  localparam int unsigned MaxStringLen = 4096;
  // Position counter must hold MaxStringLen itself.
  localparam int unsigned PosW   = $clog2(MaxStringLen + 1);
  localparam int unsigned StartW = 12;
  localparam int unsigned LenW   = 13;
  localparam int unsigned KindW  = 2;

  // Configuration register indexes.
  localparam logic CfgKeepWs = 1'b0;
  localparam logic CfgStrip  = 1'b1;

  // Token kinds.
  localparam logic [KindW-1:0] KindNormal   = 2'd0;
  localparam logic [KindW-1:0] KindQuoted   = 2'd1;
  localparam logic [KindW-1:0] KindBlank    = 2'd2;
  localparam logic [KindW-1:0] KindOpenQuot = 2'd3;

  // Character codes.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  // Result queue depth; one item pushes at most two results.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One result descriptor.
  typedef struct packed {
    logic              token_valid;
    logic [StartW-1:0] token_start;
    logic [LenW-1:0]   token_length;
    logic [KindW-1:0]  token_kind;
    logic              string_end;
    logic              run_last;
    logic              overflow;
  } res_t;

  // Results produced by one item, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// ===== hw/rtl/qts_scan.sv =====
// Scanner for the quoted token splitter: input register, tokenizer state
// and the combinational step that yields up to two results per character.
// Depends on qts_pkg.
module qts_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] char_code
  input  logic                 s_axis_tlast,   // string_last
  input  logic                 keep_ws_i,
  input  logic                 strip_i,
  input  logic                 room_i,
  output qts_pkg::push_t       push_o
);

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeNormal = 2'd1;
  localparam logic [1:0] ModeBlank  = 2'd2;
  localparam logic [1:0] ModeQuoted = 2'd3;

  // Input register.
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       fire;

  // Tokenizer state.
  logic [qts_pkg::PosW-1:0] pos_q, pos_d;
  logic [qts_pkg::PosW-1:0] begin_q, begin_d;
  logic [1:0]               mode_q, mode_d;
  logic                     dq_q, dq_d;
  logic                     ovf_q, ovf_d;

  // Step signals.
  logic                     in_range;
  logic                     is_blank;
  logic                     is_quote;
  logic [qts_pkg::PosW-1:0] pos_inc;
  logic                     a_en, c_en, b_en;
  logic [qts_pkg::PosW-1:0] a_end;
  logic [qts_pkg::KindW-1:0] a_kind, c_kind;
  qts_pkg::res_t            res_a, res_b, res_mark;

  assign fire          = in_valid_q && room_i;
  assign s_axis_tready = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ch_q   <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  // Builds a descriptor for a token that ends just before end_pos.
  function automatic qts_pkg::res_t make_token(
    input logic [qts_pkg::PosW-1:0]  tok_begin,
    input logic [qts_pkg::PosW-1:0]  end_pos,
    input logic [qts_pkg::KindW-1:0] kind,
    input logic                      strip,
    input logic                      ovf
  );
    logic [qts_pkg::PosW-1:0] len;
    logic [qts_pkg::PosW-1:0] start;
    qts_pkg::res_t            r;
    len   = end_pos - tok_begin;
    start = tok_begin;
    if (kind == qts_pkg::KindQuoted && strip && len >= qts_pkg::PosW'(2)) begin
      start = tok_begin + qts_pkg::PosW'(1);
      len   = len - qts_pkg::PosW'(2);
    end
    r.token_valid  = 1'b1;
    r.token_start  = start[qts_pkg::StartW-1:0];
    r.token_length = len[qts_pkg::LenW-1:0];
    r.token_kind   = kind;
    r.string_end   = 1'b0;
    r.run_last     = 1'b0;
    r.overflow     = ovf;
    return r;
  endfunction

  assign in_range = pos_q < qts_pkg::PosW'(qts_pkg::MaxStringLen);
  assign is_blank = (ch_q == qts_pkg::ChSpace) || (ch_q == qts_pkg::ChTab);
  assign is_quote = (ch_q == qts_pkg::ChDquote) || (ch_q == qts_pkg::ChSquote);
  assign pos_inc  = pos_q + qts_pkg::PosW'(1);

  // Per-character transition; the token closed here is result A.
  always_comb begin
    mode_d  = mode_q;
    begin_d = begin_q;
    dq_d    = dq_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    a_en    = 1'b0;
    a_end   = pos_q;
    a_kind  = qts_pkg::KindNormal;
    if (!in_range) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = pos_inc;
      unique case (mode_q)
        ModeNormal: begin
          if (is_blank) begin
            a_en    = 1'b1;
            a_kind  = qts_pkg::KindNormal;
            mode_d  = ModeBlank;
            begin_d = pos_q;
          end
        end
        ModeBlank: begin
          if (!is_blank) begin
            a_en    = keep_ws_i;
            a_kind  = qts_pkg::KindBlank;
            begin_d = pos_q;
            mode_d  = is_quote ? ModeQuoted : ModeNormal;
            dq_d    = is_quote ? (ch_q == qts_pkg::ChDquote) : dq_q;
          end
        end
        ModeQuoted: begin
          if (ch_q == (dq_q ? qts_pkg::ChDquote : qts_pkg::ChSquote)) begin
            a_en   = 1'b1;
            a_kind = qts_pkg::KindQuoted;
            a_end  = pos_inc;
            mode_d = ModeIdle;
          end
        end
        default: begin
          begin_d = pos_q;
          if (is_quote) begin
            mode_d = ModeQuoted;
            dq_d   = (ch_q == qts_pkg::ChDquote);
          end else if (is_blank) begin
            mode_d = ModeBlank;
          end else begin
            mode_d = ModeNormal;
          end
        end
      endcase
    end
  end

  // End of string: close whatever is still open (result B) or mark the end.
  always_comb begin
    c_en   = 1'b0;
    c_kind = qts_pkg::KindNormal;
    unique case (mode_d)
      ModeNormal: begin
        c_en   = 1'b1;
        c_kind = qts_pkg::KindNormal;
      end
      ModeBlank: begin
        c_en   = keep_ws_i;
        c_kind = qts_pkg::KindBlank;
      end
      ModeQuoted: begin
        c_en   = 1'b1;
        c_kind = qts_pkg::KindOpenQuot;
      end
      default: begin
        c_en = 1'b0;
      end
    endcase
  end

  assign b_en = last_q && (c_en || !a_en);

  always_comb begin
    res_a            = make_token(begin_q, a_end, a_kind, strip_i, ovf_d);
    res_a.string_end = last_q && !b_en;
    res_a.run_last   = !b_en;

    res_mark              = '0;
    res_mark.overflow     = ovf_d;
    res_mark.string_end   = 1'b1;
    res_mark.run_last     = 1'b1;

    res_b            = c_en ? make_token(begin_d, pos_d, c_kind, strip_i, ovf_d)
                            : res_mark;
    res_b.string_end = 1'b1;
    res_b.run_last   = 1'b1;
  end

  // Results to the queue, in order.
  always_comb begin
    push_o.cnt    = '0;
    push_o.first  = a_en ? res_a : res_b;
    push_o.second = res_b;
    if (fire) begin
      push_o.cnt = {1'b0, a_en} + {1'b0, b_en};
    end
  end

  // State update; the end of a string returns everything to reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      begin_q <= '0;
      mode_q  <= ModeIdle;
      dq_q    <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (fire) begin
      if (last_q) begin
        pos_q   <= '0;
        begin_q <= '0;
        mode_q  <= ModeIdle;
        dq_q    <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        begin_q <= begin_d;
        mode_q  <= mode_d;
        dq_q    <= dq_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== hw/rtl/qts_rbuf.sv =====
// Result queue for the quoted token splitter: takes up to two descriptors
// per cycle from the scanner and delivers one per transfer.
// Depends on qts_pkg.
module qts_rbuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qts_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output qts_pkg::res_t  res_o
);

  qts_pkg::res_t             entry_q [qts_pkg::QDepth];
  logic [qts_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [qts_pkg::QCntW-1:0] cnt_q;
  logic                      pop;
  logic [qts_pkg::QPtrW-1:0] wr_next;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign res_o   = entry_q[rd_q];
  // Room for a full pair of results, without counting on a pop.
  assign room_o  = cnt_q <= qts_pkg::QCntW'(qts_pkg::QDepth - 2);
  assign wr_next = wr_q + qts_pkg::QPtrW'(1);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[wr_next] <= push_i.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + qts_pkg::QPtrW'(push_i.cnt);
      rd_q  <= rd_q + qts_pkg::QPtrW'(pop);
      cnt_q <= cnt_q + qts_pkg::QCntW'(push_i.cnt) - qts_pkg::QCntW'(pop);
    end
  end

endmodule

// ===== hw/rtl/quoted_token_splitter.sv =====
// Quoted token splitter: one character per transfer in, token descriptors out.
// A character passes the input register, then its results the output queue; it
// waits in the input register while the queue lacks room. Throughput: one
// character per cycle while results average one or fewer per character and the
// output is ready; the input stalls while over two results wait in the queue.
// Reset clears all string state and both configuration registers; ready at once.
module quoted_token_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // string_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] token_start, [24:12] token_length, [25] run_last, [26] overflow
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [0] token_valid, [2:1] token_kind
  output logic        m_axis_tlast    // string_end
);

  logic           keep_ws_q;
  logic           strip_q;
  logic           room;
  qts_pkg::push_t push;
  qts_pkg::res_t  res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_ws_q <= 1'b0;
      strip_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qts_pkg::CfgKeepWs: keep_ws_q <= cfg_data_i;
        qts_pkg::CfgStrip:  strip_q   <= cfg_data_i;
        default:            keep_ws_q <= keep_ws_q;
      endcase
    end
  end

  qts_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .keep_ws_i     (keep_ws_q),
    .strip_i       (strip_q),
    .room_i        (room),
    .push_o        (push)
  );

  qts_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // Output packing.
  assign m_axis_tdata = {5'd0, res.overflow, res.run_last, res.token_length,
                         res.token_start};
  assign m_axis_tuser = {res.token_kind, res.token_valid};
  assign m_axis_tlast = res.string_end;

endmodule
